// File: rtl/core/fbpa_pkg.sv
package fbpa_pkg;

    // operation codes carried by the op field
    typedef enum logic [1:0] {
        OP_ALLOC      = 2'd0,
        OP_FREE       = 2'd1,
        OP_RESIZE     = 2'd2,
        OP_POOL_RESET = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_TOO_BIG    = 2'd1,
        ST_OOM        = 2'd2,
        ST_NOT_ALLOC  = 2'd3
    } status_t;

    // configuration register indexes
    localparam logic [1:0] CFG_ELEM_SIZE_LOG2  = 2'd0;
    localparam logic [1:0] CFG_ALIGN_LOG2      = 2'd1;
    localparam logic [1:0] CFG_SLOTS_PER_CHUNK = 2'd2;
    localparam logic [1:0] CFG_CHUNK_LIMIT     = 2'd3;

    // field widths
    localparam int unsigned CFG_DATA_W = 11;
    localparam int unsigned REQ_W      = 16;
    localparam int unsigned ADDR_W     = 22;

    // configuration reset values
    localparam logic [3:0]  RST_ELEM_SIZE_LOG2  = 4'd4;
    localparam logic [3:0]  RST_ALIGN_LOG2      = 4'd2;
    localparam logic [10:0] RST_SLOTS_PER_CHUNK = 11'd64;
    localparam logic [10:0] RST_CHUNK_LIMIT     = 11'd16;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic commit;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage

// File: rtl/core/fixed_block_pool_allocator.sv
// Fixed-size slot pool allocator. Each word on the s_ channel is one operation (allocate,
// free, resize check, pool reset) and gives exactly one result word on the m_ channel.
// Each operation is registered in the idle state and then run in the execute state; no new
// word is taken until the last one has executed. The split is set by the link memory: its
// registered read port always looks up the link of the current list head, and that data is
// ready only in the cycle after the head settles. A result sits in an output register, so the
// next word is taken while it waits; execution holds only when that register is still full.
// The link memory needs no clearing after reset, so words are taken as soon as reset is
// released. Configuration writes take effect for the next word and must be made only while
// the block is idle.
module fixed_block_pool_allocator #(
    parameter int unsigned MAX_SLOTS     = 1024,
    parameter int unsigned MAX_ELEM_LOG2 = 12
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_op,
    input  logic [fbpa_pkg::REQ_W-1:0]      s_request_size,
    input  logic [fbpa_pkg::ADDR_W-1:0]     s_address,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [fbpa_pkg::ADDR_W-1:0]     m_result_address,
    output logic [1:0]                      m_status
);

    fbpa_pkg::cmd_t cmd;
    fbpa_pkg::sts_t sts;

    // sequencing
    fbpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // pool state, link memory and result register
    fbpa_datapath #(
        .MAX_SLOTS     (MAX_SLOTS),
        .MAX_ELEM_LOG2 (MAX_ELEM_LOG2)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_op             (s_op),
        .s_request_size   (s_request_size),
        .s_address        (s_address),
        .cmd              (cmd),
        .sts              (sts),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_address (m_result_address),
        .m_status         (m_status)
    );

endmodule

// File: rtl/core/fbpa_ram.sv
module fbpa_ram #(
    parameter int unsigned WIDTH = 10,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/fbpa_datapath.sv
module fbpa_datapath #(
    parameter int unsigned MAX_SLOTS     = 1024,
    parameter int unsigned MAX_ELEM_LOG2 = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [1:0]                          s_op,
    input  logic [fbpa_pkg::REQ_W-1:0]          s_request_size,
    input  logic [fbpa_pkg::ADDR_W-1:0]         s_address,
    input  fbpa_pkg::cmd_t                      cmd,
    output fbpa_pkg::sts_t                      sts,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [fbpa_pkg::ADDR_W-1:0]         m_result_address,
    output logic [1:0]                          m_status
);

    localparam int unsigned SLOT_W = $clog2(MAX_SLOTS);
    localparam int unsigned CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int unsigned AW     = fbpa_pkg::ADDR_W;

    // configuration registers
    logic [3:0]  elem_log2_reg;
    logic [3:0]  align_log2_reg;
    logic [10:0] slots_per_chunk_reg;
    logic [10:0] chunk_limit_reg;
    logic [CNT_W-1:0] limit_reg;

    // captured word
    fbpa_pkg::op_t               op_reg;
    logic [fbpa_pkg::REQ_W-1:0]  req_reg;
    logic [AW-1:0]               addr_reg;

    // pool state
    logic [SLOT_W-1:0] head_reg, head_next;
    logic              nonempty_reg, nonempty_next;
    logic [CNT_W-1:0]  bump_reg, bump_next;

    // result register
    logic                  m_valid_reg;
    logic [AW-1:0]         m_addr_reg;
    fbpa_pkg::status_t     m_status_reg;

    logic [AW-1:0]         res_addr;
    fbpa_pkg::status_t     res_status;

    logic [3:0]        e_eff;
    logic [3:0]        a_eff;
    logic [21:0]       limit_prod;
    logic              too_big;
    logic [AW-1:0]     free_slot;
    logic [AW-1:0]     align_mask;
    logic              free_ok;
    logic [AW-1:0]     head_addr;
    logic [AW-1:0]     bump_addr;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_wdata;
    logic [SLOT_W-1:0] ram_rdata;

    // configuration write port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elem_log2_reg       <= fbpa_pkg::RST_ELEM_SIZE_LOG2;
            align_log2_reg      <= fbpa_pkg::RST_ALIGN_LOG2;
            slots_per_chunk_reg <= fbpa_pkg::RST_SLOTS_PER_CHUNK;
            chunk_limit_reg     <= fbpa_pkg::RST_CHUNK_LIMIT;
        end else if (cfg_we) begin
            unique case (cfg_index)
                fbpa_pkg::CFG_ELEM_SIZE_LOG2:  elem_log2_reg       <= cfg_wdata[3:0];
                fbpa_pkg::CFG_ALIGN_LOG2:      align_log2_reg      <= cfg_wdata[3:0];
                fbpa_pkg::CFG_SLOTS_PER_CHUNK: slots_per_chunk_reg <= cfg_wdata;
                fbpa_pkg::CFG_CHUNK_LIMIT:     chunk_limit_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // slot limit, saturated at the pool size, registered off the config
    assign limit_prod = 22'(slots_per_chunk_reg) * 22'(chunk_limit_reg);

    always_ff @(posedge aclk) begin
        limit_reg <= (32'(limit_prod) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : CNT_W'(limit_prod);
    end

    // effective slot size and alignment
    assign e_eff = (32'(elem_log2_reg) > MAX_ELEM_LOG2) ? 4'(MAX_ELEM_LOG2) : elem_log2_reg;
    assign a_eff = (align_log2_reg > e_eff) ? e_eff : align_log2_reg;

    // capture the input word
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= fbpa_pkg::op_t'(s_op);
            req_reg  <= s_request_size;
            addr_reg <= s_address;
        end
    end

    // checks and addresses
    assign too_big    = 17'(req_reg) > (17'(1) << e_eff);
    assign free_slot  = addr_reg >> e_eff;
    assign align_mask = (AW'(1) << a_eff) - AW'(1);
    assign free_ok    = ((addr_reg & align_mask) == '0) && (free_slot < AW'(bump_reg));
    assign head_addr  = AW'(32'(head_reg) << e_eff);
    assign bump_addr  = AW'(32'(bump_reg) << e_eff);

    // link memory, read address follows the list head
    fbpa_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_SLOTS)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (free_slot[SLOT_W-1:0]),
        .wdata (ram_wdata),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // execute one operation
    always_comb begin
        head_next     = head_reg;
        nonempty_next = nonempty_reg;
        bump_next     = bump_reg;
        res_addr      = '0;
        res_status    = fbpa_pkg::ST_OK;
        ram_we        = 1'b0;
        ram_wdata     = nonempty_reg ? head_reg : free_slot[SLOT_W-1:0];
        if (cmd.commit) begin
            unique case (op_reg)
                fbpa_pkg::OP_ALLOC: begin
                    if (too_big) begin
                        res_status = fbpa_pkg::ST_TOO_BIG;
                    end else if (nonempty_reg) begin
                        res_addr = head_addr;
                        // a self-link marks the tail
                        if (ram_rdata == head_reg) begin
                            nonempty_next = 1'b0;
                            head_next     = '0;
                        end else begin
                            head_next = ram_rdata;
                        end
                    end else if (bump_reg < limit_reg) begin
                        res_addr  = bump_addr;
                        bump_next = bump_reg + CNT_W'(1);
                    end else begin
                        res_status = fbpa_pkg::ST_OOM;
                    end
                end
                fbpa_pkg::OP_FREE: begin
                    if (free_ok) begin
                        ram_we        = 1'b1;
                        head_next     = free_slot[SLOT_W-1:0];
                        nonempty_next = 1'b1;
                    end else begin
                        res_status = fbpa_pkg::ST_NOT_ALLOC;
                    end
                end
                fbpa_pkg::OP_RESIZE: begin
                    if (too_big) begin
                        res_status = fbpa_pkg::ST_TOO_BIG;
                    end else begin
                        res_addr = addr_reg;
                    end
                end
                fbpa_pkg::OP_POOL_RESET: begin
                    head_next     = '0;
                    nonempty_next = 1'b0;
                    bump_next     = '0;
                end
                default: ;
            endcase
        end
    end

    // pool state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            nonempty_reg <= 1'b0;
            bump_reg     <= '0;
        end else begin
            head_reg     <= head_next;
            nonempty_reg <= nonempty_next;
            bump_reg     <= bump_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_addr_reg   <= res_addr;
            m_status_reg <= res_status;
        end
    end

    assign sts.out_free       = !m_valid_reg || m_ready;
    assign m_valid            = m_valid_reg;
    assign m_result_address   = m_addr_reg;
    assign m_status           = m_status_reg;

    // a committed result is presented next cycle
    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid_reg)
        else $error("committed result not presented");

    // an empty list keeps its head at zero
    a_empty_head: assert property (@(posedge aclk) disable iff (!aresetn)
        !nonempty_reg |-> head_reg == '0)
        else $error("empty free list with nonzero head");

    // an accepted free leaves the list non-empty
    a_free_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && op_reg == fbpa_pkg::OP_FREE && free_ok) |=> nonempty_reg)
        else $error("free did not push the slot");

endmodule

// File: rtl/core/fbpa_ctrl.sv
module fbpa_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  fbpa_pkg::sts_t sts,
    output fbpa_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // commands to the datapath
    assign s_ready     = (state_reg == S_IDLE);
    assign cmd.capture = s_valid && s_ready;
    assign cmd.commit  = (state_reg == S_EXEC) && sts.out_free;

    // an accepted word enters the execute state next cycle
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg == S_EXEC)
        else $error("accepted word not executed");

    // execution waits while the output register is held
    a_exec_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC && !sts.out_free) |=> state_reg == S_EXEC)
        else $error("execution left with output register full");

    // a commit returns to idle
    a_commit_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> state_reg == S_IDLE)
        else $error("commit did not return to idle");

endmodule
